@@ src/dma_chain_tag_engine_defines.svh @@
`ifndef DMA_CHAIN_TAG_ENGINE_DEFINES_SVH
`define DMA_CHAIN_TAG_ENGINE_DEFINES_SVH

// Checked only out of reset.
`define DCTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DCTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/dcte_pkg.sv @@
package dcte_pkg;

  localparam int AddrW       = 32;
  localparam int QwW         = 16;
  localparam int KindW       = 3;
  localparam int DepthW      = 2;
  localparam int PaddrW      = 3;
  localparam int ApbDataW    = 32;

  // Return stack; occupancy counter is two bits, so at most three entries are usable.
  localparam int STACK_DEPTH = 2;
  localparam logic [DepthW-1:0] STACK_CAP =
    DepthW'((STACK_DEPTH > 3) ? 3 : STACK_DEPTH);
  localparam int StackIdxW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [AddrW-1:0] QW_BYTES        = AddrW'(16);
  localparam logic [AddrW-1:0] ADDR_ALIGN_MASK = ~AddrW'(32'hF);
  localparam int               QW_SHIFT        = 4;

  // Register index taken from paddr[2]
  localparam logic REG_ENABLE_IRQ = 1'b0;
  localparam logic REG_CHAIN_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TAG   = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_REFE = 3'd0,
    KIND_CNT  = 3'd1,
    KIND_NEXT = 3'd2,
    KIND_REF  = 3'd3,
    KIND_REFS = 3'd4,
    KIND_CALL = 3'd5,
    KIND_RET  = 3'd6,
    KIND_END  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    PRIO_KEEP = 2'd0,
    PRIO_RSVD = 2'd1,
    PRIO_OFF  = 2'd2,
    PRIO_ON   = 2'd3
  } prio_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PRIO     = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [AddrW-1:0] addr;
    logic [QwW-1:0]   qwords;
    logic [KindW-1:0] kind;
    logic             irq;
    logic [1:0]       prio;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0]  data_address;
    logic [AddrW-1:0]  next_tag_address;
    logic [QwW-1:0]    qwords_left;
    logic              xfer_end;
    logic [DepthW-1:0] stack_depth;
    logic              stall_drain_ok;
    logic              priority_enable;
    logic [1:0]        error;
  } result_t;

endpackage

@@ src/dma_chain_tag_engine.sv @@
// Source-chain tag walker for one DMA channel. Each input transaction is a start
// (op 0, loads the tag pointer), a decoded tag (op 1) or one data quadword (op 2),
// and each yields exactly one result transaction with the pointers and status after
// the step. An item is registered on entry, processed against the channel state
// once the result register is free, and the result lands in an output register.
// One item is taken every cycle while the result is not stalled. A stalled result
// stops intake only once the input register is also full. enable_irq (byte
// address 0) and chain_mode (byte address 4) are written over the APB port; the user
// must write them only while the engine is idle, which the block does not enforce.
`include "dma_chain_tag_engine_defines.svh"

module dma_chain_tag_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcte_pkg::PaddrW-1:0]   paddr,
  input  logic [dcte_pkg::ApbDataW-1:0] pwdata,
  output logic [dcte_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [dcte_pkg::AddrW-1:0]    addr_in_i,
  input  logic [dcte_pkg::QwW-1:0]      tag_qwords_i,
  input  logic [dcte_pkg::KindW-1:0]    tag_kind_i,
  input  logic                          tag_irq_i,
  input  logic [1:0]                    tag_priority_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dcte_pkg::AddrW-1:0]    data_address_o,
  output logic [dcte_pkg::AddrW-1:0]    next_tag_address_o,
  output logic [dcte_pkg::QwW-1:0]      qwords_left_o,
  output logic                          xfer_end_o,
  output logic [dcte_pkg::DepthW-1:0]   stack_depth_o,
  output logic                          stall_drain_ok_o,
  output logic                          priority_enable_o,
  output logic [1:0]                    error_o
);
  import dcte_pkg::*;

  // config
  logic enable_irq_q, chain_mode_q;
  logic cfg_write;

  // pipeline
  logic    in_valid_q, out_valid_q;
  item_t   item_q;
  result_t res_q, res_d;
  logic    out_free, step;

  // channel state
  logic [AddrW-1:0]  tag_ptr_q, tag_ptr_d;
  logic [AddrW-1:0]  data_ptr_q, data_ptr_d;
  logic [QwW-1:0]    remaining_q, remaining_d;
  logic [KindW-1:0]  cur_kind_q, cur_kind_d;
  logic              end_flag_q, end_flag_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              drain_q, drain_d;
  logic              prio_on_q, prio_on_d;
  logic [AddrW-1:0]  ret_stack_q [STACK_DEPTH];

  logic                 push;
  logic [StackIdxW-1:0] push_idx, pop_idx;
  logic [AddrW-1:0]     push_addr, field_addr, tag_plus;
  logic [DepthW-1:0]    depth_dec;
  err_e                 err;

  // APB
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CHAIN_MODE) begin
      prdata[0] = chain_mode_q;
    end else begin
      prdata[0] = enable_irq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_irq_q <= 1'b0;
      chain_mode_q <= 1'b1;
    end else if (cfg_write) begin
      if (paddr[2] == REG_CHAIN_MODE) begin
        chain_mode_q <= pwdata[0];
      end else begin
        enable_irq_q <= pwdata[0];
      end
    end
  end

  // Handshake: input register drains into the result register whenever it is free.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.op     <= op_i;
      item_q.addr   <= addr_in_i;
      item_q.qwords <= tag_qwords_i;
      item_q.kind   <= tag_kind_i;
      item_q.irq    <= tag_irq_i;
      item_q.prio   <= tag_priority_i;
    end
  end

  // Step logic
  assign field_addr = item_q.addr & ADDR_ALIGN_MASK;
  assign tag_plus   = tag_ptr_q + QW_BYTES;
  assign push_idx   = StackIdxW'(depth_q);
  assign depth_dec  = depth_q - DepthW'(1);
  assign pop_idx    = StackIdxW'(depth_dec);
  assign push_addr  = tag_plus + (AddrW'(item_q.qwords) << QW_SHIFT);

  always_comb begin
    tag_ptr_d   = tag_ptr_q;
    data_ptr_d  = data_ptr_q;
    remaining_d = remaining_q;
    cur_kind_d  = cur_kind_q;
    end_flag_d  = end_flag_q;
    depth_d     = depth_q;
    drain_d     = drain_q;
    prio_on_d   = prio_on_q;
    push        = 1'b0;
    err         = ERR_NONE;

    case (op_e'(item_q.op))
      OP_START: begin
        tag_ptr_d   = item_q.addr;
        data_ptr_d  = '0;
        remaining_d = '0;
        cur_kind_d  = KIND_REFE;
        end_flag_d  = 1'b0;
        depth_d     = '0;
        drain_d     = 1'b0;
        prio_on_d   = 1'b0;
      end
      OP_TAG: begin
        remaining_d = item_q.qwords;
        cur_kind_d  = item_q.kind;
        drain_d     = 1'b0;
        data_ptr_d  = tag_plus;
        case (kind_e'(item_q.kind))
          KIND_REFE: begin
            data_ptr_d = field_addr;
            tag_ptr_d  = tag_plus;
            end_flag_d = 1'b1;
          end
          KIND_CNT:  tag_ptr_d = tag_plus;
          KIND_NEXT: tag_ptr_d = field_addr;
          KIND_REF: begin
            data_ptr_d = field_addr;
            tag_ptr_d  = tag_plus;
          end
          KIND_REFS: begin
            data_ptr_d = field_addr;
            tag_ptr_d  = tag_plus;
            drain_d    = 1'b1;
          end
          KIND_CALL: begin
            tag_ptr_d = field_addr;
            if (depth_q < STACK_CAP) begin
              push    = 1'b1;
              depth_d = depth_q + DepthW'(1);
            end else begin
              err = ERR_OVERFLOW;
            end
          end
          KIND_RET: begin
            if (depth_q == '0 || depth_q > STACK_CAP) begin
              end_flag_d = 1'b1;
            end else begin
              depth_d   = depth_dec;
              tag_ptr_d = ret_stack_q[pop_idx];
            end
          end
          default: end_flag_d = 1'b1;
        endcase

        if (item_q.irq && enable_irq_q) begin
          end_flag_d = 1'b1;
        end

        case (prio_e'(item_q.prio))
          PRIO_RSVD: if (err == ERR_NONE) err = ERR_PRIO;
          PRIO_OFF:  prio_on_d = 1'b0;
          PRIO_ON:   prio_on_d = 1'b1;
          default:   ;
        endcase
      end
      OP_DATA: begin
        if (remaining_q != '0) begin
          data_ptr_d  = data_ptr_q + QW_BYTES;
          remaining_d = remaining_q - QwW'(1);
          if (chain_mode_q && kind_e'(cur_kind_q) == KIND_CNT) begin
            tag_ptr_d = data_ptr_q + QW_BYTES;
          end
        end
      end
      default: ;
    endcase

    res_d.data_address     = data_ptr_d;
    res_d.next_tag_address = tag_ptr_d;
    res_d.qwords_left      = remaining_d;
    res_d.xfer_end         = end_flag_d;
    res_d.stack_depth      = depth_d;
    res_d.stall_drain_ok   = drain_d;
    res_d.priority_enable  = prio_on_d;
    res_d.error            = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_ptr_q   <= '0;
      data_ptr_q  <= '0;
      remaining_q <= '0;
      cur_kind_q  <= KIND_REFE;
      end_flag_q  <= 1'b0;
      depth_q     <= '0;
      drain_q     <= 1'b0;
      prio_on_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        tag_ptr_q   <= tag_ptr_d;
        data_ptr_q  <= data_ptr_d;
        remaining_q <= remaining_d;
        cur_kind_q  <= cur_kind_d;
        end_flag_q  <= end_flag_d;
        depth_q     <= depth_d;
        drain_q     <= drain_d;
        prio_on_q   <= prio_on_d;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  // Return stack, no reset: a pop only reads what a call pushed
  always_ff @(posedge clk_i) begin
    if (step && push) begin
      ret_stack_q[push_idx] <= push_addr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign data_address_o     = res_q.data_address;
  assign next_tag_address_o = res_q.next_tag_address;
  assign qwords_left_o      = res_q.qwords_left;
  assign xfer_end_o         = res_q.xfer_end;
  assign stack_depth_o      = res_q.stack_depth;
  assign stall_drain_ok_o   = res_q.stall_drain_ok;
  assign priority_enable_o  = res_q.priority_enable;
  assign error_o            = res_q.error;

  `DCTE_ASSERT(a_depth_cap, depth_q <= STACK_CAP, "call depth above stack capacity")
  `DCTE_ASSERT(a_call_push,
    step && item_q.op == OP_TAG && item_q.kind == KIND_CALL && depth_q < STACK_CAP
      |=> depth_q == $past(depth_q) + DepthW'(1),
    "call below capacity did not push")
  `DCTE_ASSERT(a_overflow_full,
    out_valid_q && res_q.error == ERR_OVERFLOW |-> res_q.stack_depth == STACK_CAP,
    "overflow reported with room on the stack")
  `DCTE_ASSERT(a_start_clears,
    step && item_q.op == OP_START |=> depth_q == '0 && !end_flag_q && !prio_on_q,
    "start did not clear channel state")
  `DCTE_ASSERT(a_item_held,
    in_valid_q && !step |=> in_valid_q && $stable(item_q),
    "pending item lost while result stage was blocked")

endmodule
